[rtl/dos_pkg.sv]
// Shared types, constants and key functions of the draw order sorter.
package dos_pkg;

    localparam int QueueDepth   = 256;
    localparam int HandleBits   = 12;
    localparam int PipelineBits = 16;
    localparam int DepthBits    = 32;
    localparam int RankBits     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CountBits    = $clog2(QueueDepth + 1);

    typedef logic [RankBits-1:0]  t_rank;
    typedef logic [CountBits-1:0] t_count;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_DRAIN   = 2'd1,
        CMD_DISCARD = 2'd2
    } t_cmd;

    typedef enum logic {
        ST_EMITTED = 1'b0,
        ST_DROPPED = 1'b1
    } t_status;

    typedef struct packed {
        logic                    blended;
        logic [DepthBits-1:0]    depth_key;
        logic [PipelineBits-1:0] pipeline;
        logic [HandleBits-1:0]   handle;
    } t_draw;

    // Entry of the sorted chain; rank is the entry's position in push order.
    typedef struct packed {
        logic  valid;
        t_draw draw;
        t_rank rank;
    } t_sort_entry;

    // Entry of the push-order chain.
    typedef struct packed {
        logic  valid;
        t_draw draw;
    } t_fifo_entry;

    // Broadcast from the top level to every cell of both chains.
    typedef struct packed {
        logic  push;
        logic  drain_sorted;
        logic  drain_fifo;
        logic  discard;
        t_draw new_draw;
        t_rank new_rank;
        t_rank drain_rank;
        t_draw fifo_head;
    } t_ctrl;

    // Maps float bits to an unsigned key that orders like the float; -0 maps as +0.
    function automatic logic [DepthBits-1:0] depth_to_key(input logic [DepthBits-1:0] bits);
        logic [DepthBits-1:0] b;
        logic [DepthBits-1:0] k;
        b = bits;
        if (b == {1'b1, {(DepthBits-1){1'b0}}}) begin
            b = '0;
        end
        if (b[DepthBits-1]) begin
            k = ~b;
        end else begin
            k = b | {1'b1, {(DepthBits-1){1'b0}}};
        end
        return k;
    endfunction

    // True when draw a leaves strictly before draw b under sorting, ignoring age.
    function automatic logic key_less(input t_draw a, input t_draw b);
        logic r;
        if (a.blended != b.blended) begin
            r = !a.blended;
        end else if (a.blended) begin
            r = 1'b0;
        end else if (a.depth_key != b.depth_key) begin
            r = a.depth_key < b.depth_key;
        end else begin
            r = a.pipeline < b.pipeline;
        end
        return r;
    endfunction

endpackage

[rtl/dos_sort_cell.sv]
// One cell of the chain that keeps queued draws in drawing order.
module dos_sort_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dos_pkg::t_ctrl      i_ctrl,
    input  dos_pkg::t_rank      i_index,
    input  dos_pkg::t_sort_entry i_prev,
    input  dos_pkg::t_sort_entry i_next,
    output dos_pkg::t_sort_entry o_entry
);
    import dos_pkg::*;

    t_sort_entry r_entry;
    t_sort_entry n_entry;
    logic        w_before_self;
    logic        w_before_prev;
    logic        w_keep_fifo;

    always_comb begin
        // The new draw goes ahead of an entry only when strictly smaller, so
        // equal keys stay in push order.
        w_before_self = !r_entry.valid || key_less(i_ctrl.new_draw, r_entry.draw);
        w_before_prev = (i_index != '0)
                        && (!i_prev.valid || key_less(i_ctrl.new_draw, i_prev.draw));
        // The oldest draw leaves; entries with a smaller key sit ahead of it.
        w_keep_fifo = r_entry.valid && key_less(r_entry.draw, i_ctrl.fifo_head);
    end

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctrl.discard) begin
            n_entry.valid = 1'b0;
        end else if (i_ctrl.push) begin
            if (w_before_prev) begin
                n_entry = i_prev;
            end else if (w_before_self) begin
                n_entry.valid = 1'b1;
                n_entry.draw  = i_ctrl.new_draw;
                n_entry.rank  = i_ctrl.new_rank;
            end
        end else if (i_ctrl.drain_sorted) begin
            n_entry = i_next;
            if (i_next.rank > i_ctrl.drain_rank) begin
                n_entry.rank = i_next.rank - t_rank'(1);
            end
        end else if (i_ctrl.drain_fifo) begin
            if (!w_keep_fifo) begin
                n_entry = i_next;
                n_entry.rank = i_next.rank - t_rank'(1);
            end else begin
                n_entry.rank = r_entry.rank - t_rank'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.draw <= n_entry.draw;
        r_entry.rank <= n_entry.rank;
    end

    assign o_entry = r_entry;

endmodule

[rtl/dos_fifo_cell.sv]
// One cell of the chain that keeps queued draws in push order.
module dos_fifo_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dos_pkg::t_ctrl       i_ctrl,
    input  dos_pkg::t_rank       i_index,
    input  dos_pkg::t_fifo_entry i_prev,
    input  dos_pkg::t_fifo_entry i_next,
    output dos_pkg::t_fifo_entry o_entry
);
    import dos_pkg::*;

    t_fifo_entry r_entry;
    t_fifo_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctrl.discard) begin
            n_entry.valid = 1'b0;
        end else if (i_ctrl.push) begin
            if (!r_entry.valid && ((i_index == '0) || i_prev.valid)) begin
                n_entry.valid = 1'b1;
                n_entry.draw  = i_ctrl.new_draw;
            end
        end else if (i_ctrl.drain_sorted) begin
            // The sorted head left from push position drain_rank; close the gap.
            if (i_index >= i_ctrl.drain_rank) begin
                n_entry = i_next;
            end
        end else if (i_ctrl.drain_fifo) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.draw <= n_entry.draw;
    end

    assign o_entry = r_entry;

endmodule

[rtl/draw_order_sorter.sv]
// Draw order sorter: queues draws and hands them back in drawing order.
// Input stream: tuser carries the command (push, drain, discard); tdata carries
// the pushed draw. A push stores the draw; a drain emits the next draw and
// sets tlast when the queue becomes empty; a discard empties the queue.
// A push into a full queue comes back on the output with tuser set (dropped).
// A result shows on the output register in the cycle after its transaction,
// and one command is taken per cycle while the output is free or being
// taken. Two rows of cells hold the queue, one kept sorted by key and one in
// push order; every cell compares the broadcast draw with its own entry and
// shifts. The sort_enabled register picks which row's head a drain takes and
// is written through i_cfg_we/i_cfg_wdata. Reset empties both rows, sets
// sort_enabled and clears the output. While the receiver stalls with a result
// waiting, o_s_tready is low and nothing moves.
module draw_order_sorter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // sort_enabled
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,       // blended, depth_bits, pipeline_id, draw_handle
    input  logic [1:0]  i_s_tuser,       // command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,       // handle_out
    output logic        o_m_tuser,       // status
    output logic        o_m_tlast        // last_of_pass
);
    import dos_pkg::*;

    localparam int DrawBits = 1 + DepthBits + PipelineBits + HandleBits;

    logic                  r_sort_enabled;
    t_count                r_fill;
    t_count                n_fill;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [HandleBits-1:0] r_out_handle;
    logic [HandleBits-1:0] n_out_handle;
    t_status               r_out_status;
    t_status               n_out_status;
    logic                  r_out_last;
    logic                  n_out_last;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_cmd_push;
    logic                  w_cmd_drain;
    logic                  w_cmd_discard;
    t_draw                 w_new_draw;
    t_ctrl                 w_ctrl;

    t_sort_entry           w_sort [QueueDepth];
    t_fifo_entry           w_fifo [QueueDepth];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_fill == t_count'(QueueDepth));

    always_comb begin
        w_cmd_push    = 1'b0;
        w_cmd_drain   = 1'b0;
        w_cmd_discard = 1'b0;
        unique case (i_s_tuser)
            CMD_PUSH:    w_cmd_push    = 1'b1;
            CMD_DRAIN:   w_cmd_drain   = 1'b1;
            CMD_DISCARD: w_cmd_discard = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        w_new_draw.blended   = i_s_tdata[0];
        w_new_draw.depth_key = depth_to_key(i_s_tdata[DepthBits:1]);
        w_new_draw.pipeline  = i_s_tdata[DepthBits+PipelineBits:DepthBits+1];
        w_new_draw.handle    = i_s_tdata[DrawBits-1:DepthBits+PipelineBits+1];
    end

    always_comb begin
        w_ctrl.push         = w_accept && w_cmd_push && !w_full;
        w_ctrl.drain_sorted = w_accept && w_cmd_drain && (r_fill != '0) && r_sort_enabled;
        w_ctrl.drain_fifo   = w_accept && w_cmd_drain && (r_fill != '0) && !r_sort_enabled;
        w_ctrl.discard      = w_accept && w_cmd_discard;
        w_ctrl.new_draw     = w_new_draw;
        w_ctrl.new_rank     = r_fill[RankBits-1:0];
        w_ctrl.drain_rank   = w_sort[0].rank;
        w_ctrl.fifo_head    = w_fifo[0].draw;
    end

    for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
        t_sort_entry w_sort_prev;
        t_sort_entry w_sort_next;
        t_fifo_entry w_fifo_prev;
        t_fifo_entry w_fifo_next;

        if (g == 0) begin : g_head
            assign w_sort_prev = '0;
            assign w_fifo_prev = '0;
        end else begin : g_body
            assign w_sort_prev = w_sort[g-1];
            assign w_fifo_prev = w_fifo[g-1];
        end

        if (g == QueueDepth - 1) begin : g_tail
            assign w_sort_next = '0;
            assign w_fifo_next = '0;
        end else begin : g_inner
            assign w_sort_next = w_sort[g+1];
            assign w_fifo_next = w_fifo[g+1];
        end

        dos_sort_cell u_sort_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_index (t_rank'(g)),
            .i_prev  (w_sort_prev),
            .i_next  (w_sort_next),
            .o_entry (w_sort[g])
        );

        dos_fifo_cell u_fifo_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_index (t_rank'(g)),
            .i_prev  (w_fifo_prev),
            .i_next  (w_fifo_next),
            .o_entry (w_fifo[g])
        );
    end

    always_comb begin
        n_fill       = r_fill;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_handle = r_out_handle;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        priority if (w_ctrl.discard) begin
            n_fill = '0;
        end else if (w_ctrl.push) begin
            n_fill = r_fill + t_count'(1);
        end else if (w_ctrl.drain_sorted || w_ctrl.drain_fifo) begin
            n_fill       = r_fill - t_count'(1);
            n_out_valid  = 1'b1;
            n_out_handle = w_ctrl.drain_sorted ? w_sort[0].draw.handle
                                               : w_fifo[0].draw.handle;
            n_out_status = ST_EMITTED;
            n_out_last   = (r_fill == t_count'(1));
        end else if (w_accept && w_cmd_push) begin
            n_out_valid  = 1'b1;
            n_out_handle = w_new_draw.handle;
            n_out_status = ST_DROPPED;
            n_out_last   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_enabled <= 1'b1;
            r_fill         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sort_enabled <= i_cfg_wdata;
            end
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_out_handle <= n_out_handle;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(16-HandleBits){1'b0}}, r_out_handle};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_empty_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) == (!w_sort[0].valid && !w_fifo[0].valid))
        else $error("queue heads disagree with fill count");

    a_full_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> (w_sort[QueueDepth-1].valid && w_fifo[QueueDepth-1].valid))
        else $error("full queue without a valid tail cell");

    a_discard_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.discard |=> (r_fill == '0) && !w_sort[0].valid && !w_fifo[0].valid)
        else $error("discard left entries behind");

    a_drop_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_DROPPED)) |-> !r_out_last)
        else $error("dropped push marked as last of pass");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd_push && !w_full) |=> (r_fill == $past(r_fill) + t_count'(1)))
        else $error("push into a queue with room did not grow it");
`endif

endmodule
